FILE: src/msr_pkg.sv
// Shared types and constants for the multi-channel servo ramp block.
// Depends on nothing; multi_channel_servo_ramp imports it.
`timescale 1ns / 1ps

package msr_pkg;

  typedef enum logic [1:0] {
    CmdTick = 2'd0,
    CmdSet  = 2'd1,
    CmdStop = 2'd2
  } cmd_e;

  localparam logic [7:0] ResetAngle = 8'd90;
  localparam logic [6:0] SpeedMin   = 7'd1;
  localparam logic [6:0] SpeedMax   = 7'd100;
  localparam int unsigned PwmMax    = 4095;

  // One command item as it arrives.
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] channel;
    logic [7:0] angle;
    logic [6:0] speed;
  } cmd_item_t;

  // One status item as it leaves.
  typedef struct packed {
    logic [3:0]  out_channel;
    logic [7:0]  cur_angle;
    logic        moving;
    logic [11:0] pwm_value;
    logic        pwm_written;
    logic [4:0]  stopped_count;
    logic        last;
  } status_t;

  // Per-channel state word kept in the state RAM.
  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] tgt;
    logic [6:0] spd;
    logic       mov;
  } entry_t;

  localparam entry_t ResetEntry = '{cur: ResetAngle, tgt: ResetAngle, spd: 7'd0, mov: 1'b0};

endpackage

FILE: src/msr_stream_if.sv
// Valid/ready stream channel carrying one item of a given payload type.
// Depends on nothing; the payload type is passed in as a parameter.
`timescale 1ns / 1ps

interface msr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/msr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module msr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/multi_channel_servo_ramp.sv
// Channel  | dir | payload                                   | handshake
// cmd_if_i | in  | cmd, channel, angle, speed                | valid/ready
// status_if_o | out | out_channel, cur_angle, moving, pwm_value,| valid/ready
//          |     | pwm_written, stopped_count, last          |
//
// A tick or stop-all accepts the item and issues the first state RAM read, then
// sweeps the channels in turn through the single read-modify-write path of the
// RAM; a set updates only its channel. Reset needs no clearing pass: per-channel
// valid flops make unwritten entries read as their reset value. A stalled status
// output holds a tick or set, but a stop-all only on its last channel; the next
// item is taken while the final status item still waits in the output register.
//
// Servo slew-rate limiter top level; uses msr_pkg, msr_stream_if and msr_ram.
`timescale 1ns / 1ps

module multi_channel_servo_ramp #(
  parameter int unsigned Channels = 16,
  parameter int unsigned MaxAngle = 180
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  msr_stream_if.sink   cmd_if_i,
  msr_stream_if.source status_if_o
);
  import msr_pkg::*;

  localparam int unsigned ChW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [ChW-1:0] LastCh = ChW'(Channels - 1);
  localparam logic [7:0] MaxAng = 8'(MaxAngle);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  logic [11:0] pwm_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_pwm
    localparam int unsigned Ac = (g > MaxAngle) ? MaxAngle : g;
    localparam int unsigned Pv = ((4 * MaxAngle + 22 * Ac) * 512) / (25 * MaxAngle);
    assign pwm_tab[g] = (Pv > PwmMax) ? 12'(PwmMax) : 12'(Pv);
  end

  state_e         state_q;
  cmd_e           cmd_q;
  logic [ChW-1:0] idx_q;
  logic [7:0]     ang_q;
  logic [6:0]     spd_q;
  logic [4:0]     cnt_q;
  logic           rd_vld_q;
  logic [Channels-1:0] vld_q;
  logic           out_valid_q;
  status_t        out_q;

  cmd_item_t      in_item;
  logic           in_acc;
  logic           ch_ok;
  logic           start;
  logic [7:0]     ang_clamp;
  logic [6:0]     spd_clamp;

  logic           last_idx;
  logic           out_free;
  logic           fire;
  logic           emit;

  logic           ram_re;
  logic [ChW-1:0] ram_raddr;
  entry_t         ram_rdata;
  entry_t         ent;
  entry_t         nxt;
  logic           wr;
  logic [2:0]     step;
  logic [7:0]     mag;
  logic           up;
  status_t        res;

  assign in_item = cmd_if_i.data;
  assign cmd_if_i.ready = (state_q == StIdle);
  assign in_acc = cmd_if_i.valid && cmd_if_i.ready;
  assign ch_ok  = ({1'b0, in_item.channel} < 5'(Channels));
  assign start  = in_acc && ((in_item.cmd == CmdTick) || (in_item.cmd == CmdStop) ||
                             ((in_item.cmd == CmdSet) && ch_ok));

  assign ang_clamp = (in_item.angle > MaxAng) ? MaxAng : in_item.angle;
  always_comb begin
    spd_clamp = in_item.speed;
    if (in_item.speed < SpeedMin) spd_clamp = SpeedMin;
    if (in_item.speed > SpeedMax) spd_clamp = SpeedMax;
  end

  assign last_idx = (cmd_q == CmdSet) || (idx_q == LastCh);
  assign out_free = !out_valid_q || status_if_o.ready;
  assign fire     = (state_q == StRun) && (out_free || ((cmd_q == CmdStop) && !last_idx));
  assign emit     = fire && ((cmd_q != CmdStop) || last_idx);

  // Read the first entry on accept, then the next one each time a channel retires.
  assign ram_re    = start || (fire && !last_idx);
  assign ram_raddr = (state_q == StIdle)
                   ? ((in_item.cmd == CmdSet) ? in_item.channel[ChW-1:0] : '0)
                   : idx_q + ChW'(1);

  msr_ram #(
    .Width($bits(entry_t)),
    .Depth(Channels)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (idx_q),
    .wdata_i (nxt),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent = rd_vld_q ? ram_rdata : ResetEntry;

  // speed*5/100 equals speed/20; never less than one degree.
  always_comb begin
    if (ent.spd >= 7'd100)     step = 3'd5;
    else if (ent.spd >= 7'd80) step = 3'd4;
    else if (ent.spd >= 7'd60) step = 3'd3;
    else if (ent.spd >= 7'd40) step = 3'd2;
    else                       step = 3'd1;
  end

  assign up  = ent.tgt > ent.cur;
  assign mag = up ? (ent.tgt - ent.cur) : (ent.cur - ent.tgt);

  always_comb begin
    nxt = ent;
    wr  = 1'b0;
    case (cmd_q)
      CmdTick: begin
        if (ent.mov) begin
          if (mag == 8'd0) begin
            nxt.mov = 1'b0;
          end else begin
            wr = 1'b1;
            if (mag <= {5'd0, step}) begin
              nxt.cur = ent.tgt;
              nxt.mov = 1'b0;
            end else if (up) begin
              nxt.cur = ent.cur + {5'd0, step};
            end else begin
              nxt.cur = ent.cur - {5'd0, step};
            end
          end
        end
      end
      CmdSet: begin
        nxt.tgt = ang_q;
        nxt.spd = spd_q;
        if (ang_q != ent.cur) nxt.mov = 1'b1;
      end
      CmdStop: begin
        if (ent.mov) begin
          nxt.tgt = ent.cur;
          nxt.mov = 1'b0;
        end
      end
      default: begin
        nxt = ent;
      end
    endcase
  end

  always_comb begin
    res = '0;
    res.last = last_idx;
    if (cmd_q == CmdStop) begin
      res.stopped_count = cnt_q + 5'(ent.mov);
    end else begin
      res.out_channel = 4'(idx_q);
      res.cur_angle   = nxt.cur;
      res.moving      = nxt.mov;
      res.pwm_value   = pwm_tab[nxt.cur];
      res.pwm_written = wr;
    end
  end

  assign status_if_o.valid = out_valid_q;
  assign status_if_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= CmdTick;
      idx_q       <= '0;
      ang_q       <= '0;
      spd_q       <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (ram_re) begin
        rd_vld_q <= vld_q[ram_raddr];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (status_if_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StRun;
            cmd_q   <= cmd_e'(in_item.cmd);
            idx_q   <= (in_item.cmd == CmdSet) ? in_item.channel[ChW-1:0] : '0;
            ang_q   <= ang_clamp;
            spd_q   <= spd_clamp;
            cnt_q   <= '0;
          end
        end
        StRun: begin
          if (fire) begin
            vld_q[idx_q] <= 1'b1;
            cnt_q <= cnt_q + 5'((cmd_q == CmdStop) && ent.mov);
            if (last_idx) begin
              state_q <= StIdle;
            end else begin
              idx_q <= idx_q + ChW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_if_o.valid |-> (status_if_o.data.stopped_count <= 5'(Channels)))
    else $error("stop count exceeds channel count");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_if_o.valid |-> (status_if_o.data.cur_angle <= MaxAng))
    else $error("reported angle beyond maximum");

  a_tick_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (cmd_q == CmdTick)) |-> ((idx_q == LastCh) == res.last))
    else $error("tick last flag not on final channel");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !status_if_o.ready) |-> !emit)
    else $error("status item overwritten while stalled");

  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last_idx) |=> (state_q == StRun))
    else $error("sweep left run state before last channel");
`endif

endmodule
